// ===== hdl/mbtd_pkg.sv =====
package mbtd_pkg;

  // Default build values
  localparam int CHANNELS_DEF    = 8;
  localparam int SAMPLE_BITS_DEF = 10;
  localparam int BASE_SHIFT_DEF  = 12;

  // Configuration register widths
  localparam int THR_W     = 8;
  localparam int DIST_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 1'b0,
    CFG_DISTANCE  = 1'b1
  } cfg_reg_t;

  // Register reset values
  localparam logic [THR_W-1:0]  THRESHOLD_RST = 8'd16;
  localparam logic [DIST_W-1:0] DISTANCE_RST  = 16'd10;

endpackage

// ===== hdl/mbtd_front.sv =====
// Input stage: reference/sensor phase, round-robin channel counter and
// the sensor word register that feeds the tracking stage.
module mbtd_front import mbtd_pkg::*; #(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int CH_W       = $clog2(CHANNELS)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   in_stall,
  input  logic                   s1_adv,
  output logic                   s1_valid,
  output logic [SAMPLE_BITS-1:0] s1_sample,
  output logic [CH_W-1:0]        s1_channel
);

  logic                   phase_r, phase_nxt;
  logic [CH_W-1:0]        chan_r, chan_nxt;
  logic                   s1_valid_r, s1_valid_nxt;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic [CH_W-1:0]        s1_channel_r;
  logic                   accept;
  logic                   load;

  assign in_stall = s1_valid_r & ~s1_adv;
  assign accept   = in_valid & ~in_stall;
  // Only sensor conversions (odd phase) go on; reference words are dropped
  assign load     = accept & phase_r;

  always_comb begin
    phase_nxt    = phase_r;
    chan_nxt     = chan_r;
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      phase_nxt = ~phase_r;
    end
    if (load) begin
      s1_valid_nxt = 1'b1;
      if (chan_r == CH_W'(CHANNELS - 1)) begin
        chan_nxt = '0;
      end else begin
        chan_nxt = chan_r + 1'b1;
      end
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= 1'b0;
      chan_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      chan_r     <= chan_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_sample_r  <= in_sample;
      s1_channel_r <= chan_r;
    end
  end

  assign s1_valid   = s1_valid_r;
  assign s1_sample  = s1_sample_r;
  assign s1_channel = s1_channel_r;

endmodule

// ===== hdl/mbtd_track.sv =====
// Baseline accumulators, deviation/threshold logic and result register.
module mbtd_track import mbtd_pkg::*; #(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int BASE_SHIFT  = BASE_SHIFT_DEF,
  localparam int CH_W       = $clog2(CHANNELS),
  localparam int ACC_W      = SAMPLE_BITS + BASE_SHIFT,
  localparam int DEV_W      = SAMPLE_BITS + 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    s1_valid,
  input  logic [SAMPLE_BITS-1:0]  s1_sample,
  input  logic [CH_W-1:0]         s1_channel,
  output logic                    s1_adv,
  input  logic [THR_W-1:0]        threshold,
  input  logic [DIST_W-1:0]       detect_distance,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CH_W-1:0]         out_channel,
  output logic [SAMPLE_BITS-1:0]  out_raw_sample,
  output logic signed [DEV_W-1:0] out_deviation,
  output logic                    out_detected,
  output logic [DIST_W-1:0]       out_distance_out
);

  logic [ACC_W-1:0]        acc_r [CHANNELS];
  logic [ACC_W-1:0]        acc_cur;
  logic [ACC_W-1:0]        acc_seed;
  logic [ACC_W-1:0]        acc_nxt;
  logic [SAMPLE_BITS-1:0]  base_new;
  logic signed [DEV_W-1:0] dev;
  logic signed [DEV_W-1:0] thr_s;
  logic                    hit;

  logic                    out_valid_r, out_valid_nxt;
  logic [CH_W-1:0]         out_channel_r;
  logic [SAMPLE_BITS-1:0]  out_raw_r;
  logic signed [DEV_W-1:0] out_dev_r;
  logic                    out_hit_r;
  logic [DIST_W-1:0]       out_dist_r;

  assign s1_adv = s1_valid & (~out_valid_r | ~out_stall);

  // Zero accumulator = uninitialized: seed with sample << BASE_SHIFT
  assign acc_cur  = acc_r[s1_channel];
  assign acc_seed = (acc_cur == '0) ? {s1_sample, {BASE_SHIFT{1'b0}}} : acc_cur;
  assign acc_nxt  = acc_seed - ACC_W'(acc_seed[ACC_W-1:BASE_SHIFT]) + ACC_W'(s1_sample);
  assign base_new = acc_nxt[ACC_W-1:BASE_SHIFT];

  assign dev   = $signed({1'b0, s1_sample}) - $signed({1'b0, base_new});
  assign thr_s = $signed({{(DEV_W - THR_W){1'b0}}, threshold});
  assign hit   = dev > thr_s;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        acc_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        acc_r[s1_channel] <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_channel_r <= s1_channel;
      out_raw_r     <= s1_sample;
      out_dev_r     <= dev;
      out_hit_r     <= hit;
      out_dist_r    <= hit ? detect_distance : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_channel      = out_channel_r;
  assign out_raw_sample   = out_raw_r;
  assign out_deviation    = out_dev_r;
  assign out_detected     = out_hit_r;
  assign out_distance_out = out_dist_r;

endmodule

// ===== hdl/multichannel_baseline_threshold_detector_top.sv =====
// Channel   Handshake          Payload
// in_       valid / stall      sample
// out_      valid / stall      channel, raw_sample, deviation, detected, distance_out
// cfg_      valid / ready      index (0 threshold, 1 detect_distance), data
//
// One word per cycle in while in_stall is low. A sensor word passes the input register
// and then the result register; a new word can enter while the last one is held.
// Reference words are swallowed at the input and produce nothing.
// Synchronous reset (rst_n low) clears accumulators, phase, channel counter and valid
// flags and sets the config registers to their reset values. in_stall rises only when
// the input register is full and the result register is full and stalled; cfg_ready is always high.
module multichannel_baseline_threshold_detector_top import mbtd_pkg::*; #(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int BASE_SHIFT  = BASE_SHIFT_DEF,
  localparam int CH_W       = $clog2(CHANNELS),
  localparam int DEV_W      = SAMPLE_BITS + 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input words
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SAMPLE_BITS-1:0]  in_sample,
  // result words
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CH_W-1:0]         out_channel,
  output logic [SAMPLE_BITS-1:0]  out_raw_sample,
  output logic signed [DEV_W-1:0] out_deviation,
  output logic                    out_detected,
  output logic [DIST_W-1:0]       out_distance_out,
  // configuration writes
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DAT_W-1:0]    cfg_data
);

  logic [THR_W-1:0]       threshold_r;
  logic [DIST_W-1:0]      distance_r;
  logic                   cfg_wr;

  logic                   s1_valid;
  logic                   s1_adv;
  logic [SAMPLE_BITS-1:0] s1_sample;
  logic [CH_W-1:0]        s1_channel;

  // Config registers; the user is to write only while the pipeline is empty; the block has no check for it
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RST;
      distance_r  <= DISTANCE_RST;
    end else if (cfg_wr) begin
      case (cfg_reg_t'(cfg_index))
        CFG_THRESHOLD: threshold_r <= cfg_data[THR_W-1:0];
        CFG_DISTANCE:  distance_r  <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Phase tracking, channel round-robin, input register
  mbtd_front #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_sample  (in_sample),
    .in_stall   (in_stall),
    .s1_adv     (s1_adv),
    .s1_valid   (s1_valid),
    .s1_sample  (s1_sample),
    .s1_channel (s1_channel)
  );

  // Baseline update and detection; accumulators written as the word
  // moves into the result register
  mbtd_track #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .BASE_SHIFT  (BASE_SHIFT)
  ) u_track (
    .clk              (clk),
    .rst_n            (rst_n),
    .s1_valid         (s1_valid),
    .s1_sample        (s1_sample),
    .s1_channel       (s1_channel),
    .s1_adv           (s1_adv),
    .threshold        (threshold_r),
    .detect_distance  (distance_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_channel      (out_channel),
    .out_raw_sample   (out_raw_sample),
    .out_deviation    (out_deviation),
    .out_detected     (out_detected),
    .out_distance_out (out_distance_out)
  );

endmodule
